// ===== hdl/keypad_numeric_entry_assert.svh =====
// assertion macros for the keypad numeric entry block
// used by kne_entry, no other dependencies
`ifndef KEYPAD_NUMERIC_ENTRY_ASSERT_SVH
`define KEYPAD_NUMERIC_ENTRY_ASSERT_SVH
`ifndef SYNTHESIS
`define KNE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KNE_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KNE_ASSERT(label, clk, rst, prop, msg)
`define KNE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/kne_pkg.sv =====
// shared types, constants and key layout for the keypad numeric entry block
// no dependencies
package kne_pkg;

   localparam int          MAX_KEYS_DEF    = 15;
   localparam logic [15:0] REPEAT_RESET    = 16'd1000;
   localparam logic [30:0] VALUE_MAX       = 31'h7FFF_FFFF;
   localparam logic [4:0]  NO_KEY          = 5'd16;

   localparam logic [6:0]  CH_HASH = 7'h23;
   localparam logic [6:0]  CH_D    = 7'h44;
   localparam logic [6:0]  CH_0    = 7'h30;
   localparam logic [6:0]  CH_9    = 7'h39;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_APPENDED  = 3'd1,
      EV_CLEARED   = 3'd2,
      EV_COMMITTED = 3'd3,
      EV_REJECTED  = 3'd4,
      EV_DROPPED   = 3'd5
   } event_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] code;
      logic [6:0] ch;
   } key_type;

   function automatic logic [6:0] layout_char(input logic [3:0] code);
      logic [6:0] ch;
      unique case (code)
         4'd0:  ch = 7'h2A;
         4'd1:  ch = 7'h30;
         4'd2:  ch = 7'h23;
         4'd3:  ch = 7'h44;
         4'd4:  ch = 7'h37;
         4'd5:  ch = 7'h38;
         4'd6:  ch = 7'h39;
         4'd7:  ch = 7'h43;
         4'd8:  ch = 7'h34;
         4'd9:  ch = 7'h35;
         4'd10: ch = 7'h36;
         4'd11: ch = 7'h42;
         4'd12: ch = 7'h31;
         4'd13: ch = 7'h32;
         4'd14: ch = 7'h33;
         default: ch = 7'h41;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/keypad_numeric_entry.sv =====
// keypad numeric entry top level: handshakes, input register, repeat register
// depends on kne_pkg, kne_decode and kne_entry
//
// usage
//   req channel: one matrix scan word (req_key_data, active low, low byte
//   columns, high byte rows) with its millisecond tick (req_time_ms).
//   rsp channel: one result per transfer, event code, decoded key character,
//   committed value and keys held in the entry.
//   csr port: csr_wr_en writes csr_wr_data into the hold-repeat interval.
//   a request passes through the input register, then through decode and
//   entry update into the result register that drives rsp_valid.
//   throughput is one item per cycle while the receiver does not stall;
//   the entry state is updated in the same cycle as the result register is
//   loaded. when the receiver stalls the result holds and one further item
//   waits in the input register; after that req_stall rises.
//   synchronous reset empties both registers, clears the entry, forgets the
//   last key and sets the interval to 1000 ms.
module keypad_numeric_entry import kne_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_key_data,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [6:0]  rsp_key_char,
   output logic [30:0] rsp_value,
   output logic [3:0]  rsp_key_count,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  col_ff;
   logic [3:0]  row_ff;
   logic [31:0] time_ff;
   logic [15:0] interval_ff;

   logic        out_free;
   logic        advance;
   logic        take;
   key_type     key;
   event_type   event_res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         interval_ff  <= REPEAT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         col_ff  <= req_key_data[3:0];
         row_ff  <= req_key_data[11:8];
         time_ff <= req_time_ms;
      end
   end

   kne_decode u_decode (
      .col_bits (col_ff),
      .row_bits (row_ff),
      .key      (key)
   );

   kne_entry #(
      .MAX_KEYS (MAX_KEYS)
   ) u_entry (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .key       (key),
      .now       (time_ff),
      .interval  (interval_ff),
      .event_res (event_res),
      .key_char  (rsp_key_char),
      .value     (rsp_value),
      .key_count (rsp_key_count)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = event_res;

endmodule

// ===== hdl/kne_decode.sv =====
// matrix word decode: lowest active-low column and row, layout lookup
// depends on kne_pkg
module kne_decode import kne_pkg::*; (
   input  logic [3:0] col_bits,
   input  logic [3:0] row_bits,
   output key_type    key
);

   logic [1:0] col_idx;
   logic [1:0] row_idx;

   always_comb begin
      col_idx = 2'd0;
      row_idx = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (!col_bits[i]) begin
            col_idx = 2'(i);
         end
         if (!row_bits[i]) begin
            row_idx = 2'(i);
         end
      end
      key.hit  = (col_bits != 4'hF) && (row_bits != 4'hF);
      key.code = {row_idx, col_idx};
      key.ch   = key.hit ? layout_char({row_idx, col_idx}) : 7'd0;
   end

endmodule

// ===== hdl/kne_entry.sv =====
// entry state, repeat timing, decimal accumulator and result register
// depends on kne_pkg and keypad_numeric_entry_assert.svh
`include "keypad_numeric_entry_assert.svh"
module kne_entry import kne_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  key_type     key,
   input  logic [31:0] now,
   input  logic [15:0] interval,
   output event_type   event_res,
   output logic [6:0]  key_char,
   output logic [30:0] value,
   output logic [3:0]  key_count
);

   localparam int CW = $clog2(MAX_KEYS + 1);

   logic [4:0]    last_key_ff, last_key_in;
   logic [31:0]   stamp_ff, stamp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [30:0]   value_ff, value_in;
   logic          nondigit_ff, nondigit_in;

   event_type     ev_in;
   logic [30:0]   val_in;
   logic          try_append;
   logic          is_digit;
   logic [31:0]   elapsed;
   logic [34:0]   scaled;
   logic [CW+3:0] count_ext;

   event_type     event_ff;
   logic [6:0]    char_ff;
   logic [30:0]   val_ff;
   logic [3:0]    kcount_ff;

   always_comb begin
      last_key_in = last_key_ff;
      stamp_in    = stamp_ff;
      count_in    = count_ff;
      value_in    = value_ff;
      nondigit_in = nondigit_ff;
      ev_in       = EV_NONE;
      val_in      = '0;
      try_append  = 1'b0;
      is_digit    = (key.ch >= CH_0) && (key.ch <= CH_9);
      elapsed     = now - stamp_ff;
      scaled      = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
                    + {31'b0, key.ch[3:0]};
      if (key.hit) begin
         last_key_in = {1'b0, key.code};
         if (key.ch == CH_HASH) begin
            ev_in       = nondigit_ff ? EV_REJECTED : EV_COMMITTED;
            val_in      = nondigit_ff ? 31'd0 : value_ff;
            count_in    = '0;
            value_in    = '0;
            nondigit_in = 1'b0;
         end else if (key.ch == CH_D) begin
            ev_in       = EV_CLEARED;
            count_in    = '0;
            value_in    = '0;
            nondigit_in = 1'b0;
         end else if ({1'b0, key.code} == last_key_ff) begin
            if (elapsed > {16'b0, interval}) begin
               try_append = 1'b1;
               stamp_in   = now;
            end
         end else begin
            try_append = 1'b1;
         end
         if (try_append) begin
            if (count_ff >= CW'(MAX_KEYS)) begin
               ev_in = EV_DROPPED;
            end else begin
               ev_in    = EV_APPENDED;
               count_in = count_ff + 1'b1;
               if (is_digit) begin
                  value_in = (scaled > {4'b0, VALUE_MAX}) ? VALUE_MAX : scaled[30:0];
               end else begin
                  nondigit_in = 1'b1;
               end
            end
         end
      end
      count_ext = {4'b0, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff <= NO_KEY;
         stamp_ff    <= '0;
         count_ff    <= '0;
         value_ff    <= '0;
         nondigit_ff <= 1'b0;
      end else if (load) begin
         last_key_ff <= last_key_in;
         stamp_ff    <= stamp_in;
         count_ff    <= count_in;
         value_ff    <= value_in;
         nondigit_ff <= nondigit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff  <= ev_in;
         char_ff   <= key.ch;
         val_ff    <= val_in;
         kcount_ff <= count_ext[3:0];
      end
   end

   assign event_res = event_ff;
   assign key_char  = char_ff;
   assign value     = val_ff;
   assign key_count = kcount_ff;

   `KNE_ASSERT(a_clear_empties, clock, reset, load && (ev_in == EV_COMMITTED || ev_in == EV_REJECTED || ev_in == EV_CLEARED) |=> count_ff == '0 && value_ff == '0 && !nondigit_ff, "entry not empty after commit or clear")
   `KNE_ASSERT(a_append_counts, clock, reset, load && ev_in == EV_APPENDED |=> count_ff == $past(count_ff) + 1'b1, "append did not advance key count")
   `KNE_ASSERT(a_drop_holds, clock, reset, load && ev_in == EV_DROPPED |=> count_ff == CW'(MAX_KEYS) && $stable(value_ff) && $stable(nondigit_ff), "dropped key changed the entry")
   `KNE_ASSERT_NR(a_count_bound, clock, reset || count_ff <= CW'(MAX_KEYS), "key count above limit")

endmodule
